### src/mspc_pkg.sv
`timescale 1ns / 1ps
// mspc_pkg: shared sizes, codes and record types of the multi-stack pool checker
// no dependencies; used by every other file of the block except mspc_ram

package mspc_pkg;

    localparam int MAX_STACKS   = 1024;
    localparam int POOL_ENTRIES = 1024;
    localparam int TAG_BITS     = 16;

    localparam int STACK_AW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int POOL_AW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int FRESH_W  = POOL_AW + 1;
    localparam int TOT_W    = $clog2(POOL_ENTRIES + 1);

    localparam int NUM_W     = 11;
    localparam int ITAG_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] STACKS_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 11'd1024;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STACKS_IN_USE = 1'b0,
        CFG_ITEM_LIMIT    = 1'b1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_STACK    = 3'd1,
        ST_OVER_LIMIT   = 3'd2,
        ST_EMPTY_POP    = 3'd3,
        ST_TAG_MISMATCH = 3'd4,
        ST_NOT_EMPTY    = 3'd5,
        ST_IGNORED      = 3'd6
    } t_status;

    typedef struct packed {
        logic               nonempty;
        logic [POOL_AW-1:0] top;
    } t_stk_row;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [POOL_AW-1:0]  below;
    } t_ent_row;

    typedef struct packed {
        logic                we;
        logic [STACK_AW-1:0] waddr;
        t_stk_row            wdata;
        logic [STACK_AW-1:0] raddr;
    } t_stk_req;

    typedef struct packed {
        logic               we;
        logic [POOL_AW-1:0] waddr;
        t_ent_row           wdata;
        logic [POOL_AW-1:0] raddr;
    } t_ent_req;

    typedef struct packed {
        t_status          status;
        logic             run_failed;
        logic [CNT_W-1:0] item_total;
        logic [CNT_W-1:0] peak_total;
        logic             run_done;
    } t_result;

endpackage

### src/mspc_if.sv
`timescale 1ns / 1ps
// mspc_cmd_if and mspc_res_if: valid/ready channels for commands and results
// depends on mspc_pkg for field widths

interface mspc_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [mspc_pkg::NUM_W-1:0]  stack_number;
    logic [mspc_pkg::ITAG_W-1:0] item_tag;
    logic                        last_command;

    modport source(output valid, mode, stack_number, item_tag, last_command, input ready);
    modport sink(input valid, mode, stack_number, item_tag, last_command, output ready);
endinterface

interface mspc_res_if;
    logic                          valid;
    logic                          ready;
    logic [mspc_pkg::STATUS_W-1:0] status;
    logic                          run_failed;
    logic [mspc_pkg::CNT_W-1:0]    item_total;
    logic [mspc_pkg::CNT_W-1:0]    peak_total;
    logic                          run_done;

    modport source(output valid, status, run_failed, item_total, peak_total, run_done,
                   input ready);
    modport sink(input valid, status, run_failed, item_total, peak_total, run_done,
                 output ready);
endinterface

### src/mspc_ram.sv
`timescale 1ns / 1ps
// mspc_ram: generic memory, one write port and one read port, registered read data
// no dependencies

module mspc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/mspc_core.sv
`timescale 1ns / 1ps
// mspc_core: command sequencer, run counters, free list and result register
// depends on mspc_pkg and mspc_if; drives the stack-top and entry memories

module mspc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mspc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mspc_pkg::CFG_W-1:0]          i_cfg_data,
    mspc_cmd_if.sink                            i_cmd,
    mspc_res_if.source                          o_res,
    output mspc_pkg::t_stk_req                  o_stk_req,
    input  mspc_pkg::t_stk_row                  i_stk_rd,
    output mspc_pkg::t_ent_req                  o_ent_req,
    input  mspc_pkg::t_ent_row                  i_ent_rd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_POP,
        S_HOLD
    } t_state;

    localparam logic [mspc_pkg::STACK_AW-1:0] CLR_LAST =
        mspc_pkg::STACK_AW'(mspc_pkg::MAX_STACKS - 1);

    t_state                            r_state, n_state;
    logic [mspc_pkg::STACK_AW-1:0]     r_clr, n_clr;
    logic [mspc_pkg::CFG_W-1:0]        r_stacks, r_limit;
    logic                              r_mode, r_bad, r_last;
    logic [mspc_pkg::STACK_AW-1:0]     r_s;
    logic [mspc_pkg::TAG_BITS-1:0]     r_tag;
    logic [mspc_pkg::POOL_AW-1:0]      r_top, n_top;
    logic [mspc_pkg::POOL_AW-1:0]      r_free_head, n_free_head;
    logic                              r_free_ne, n_free_ne;
    logic [mspc_pkg::FRESH_W-1:0]      r_fresh, n_fresh;
    logic [mspc_pkg::TOT_W-1:0]        r_total, n_total;
    logic [mspc_pkg::TOT_W-1:0]        r_peak, n_peak;
    logic                              r_err, n_err;
    logic                              r_out_valid, n_out_valid;
    mspc_pkg::t_result                 r_out, n_out, r_pend, n_pend, res;

    logic                              cmd_acc, cmd_bad, fin, at_limit, fresh_full, out_free;
    logic [mspc_pkg::STACK_AW-1:0]     cmd_s;
    logic [mspc_pkg::POOL_AW-1:0]      push_idx;
    mspc_pkg::t_status                 op_st, res_st;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_acc     = i_cmd.valid && (r_state == S_IDLE);
    assign cmd_s       = mspc_pkg::STACK_AW'(i_cmd.stack_number - mspc_pkg::NUM_W'(1));
    assign cmd_bad     = (i_cmd.stack_number == '0) || (i_cmd.stack_number > r_stacks)
                         || (32'(i_cmd.stack_number) > 32'(mspc_pkg::MAX_STACKS));

    assign at_limit   = (32'(r_total) >= 32'(r_limit))
                        || (32'(r_total) >= 32'(mspc_pkg::POOL_ENTRIES));
    assign fresh_full = 32'(r_fresh) >= 32'(mspc_pkg::POOL_ENTRIES);
    assign push_idx   = r_free_ne ? r_free_head : mspc_pkg::POOL_AW'(r_fresh);
    assign out_free   = !r_out_valid || o_res.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.run_failed = r_out.run_failed;
    assign o_res.item_total = r_out.item_total;
    assign o_res.peak_total = r_out.peak_total;
    assign o_res.run_done   = r_out.run_done;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_top       = r_top;
        n_free_head = r_free_head;
        n_free_ne   = r_free_ne;
        n_fresh     = r_fresh;
        n_total     = r_total;
        n_peak      = r_peak;
        n_err       = r_err;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        n_pend      = r_pend;
        o_stk_req       = '0;
        o_stk_req.raddr = cmd_s;
        o_ent_req       = '0;
        o_ent_req.raddr = r_free_head;
        fin    = 1'b0;
        op_st  = mspc_pkg::ST_OK;
        res_st = mspc_pkg::ST_OK;
        res    = '0;

        case (r_state)
            S_CLEAR: begin
                o_stk_req.we    = 1'b1;
                o_stk_req.waddr = r_clr;
                n_clr = r_clr + mspc_pkg::STACK_AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_err) begin
                    fin   = 1'b1;
                    op_st = mspc_pkg::ST_IGNORED;
                end else if (r_bad) begin
                    fin   = 1'b1;
                    op_st = mspc_pkg::ST_BAD_STACK;
                end else if (r_mode == mspc_pkg::MODE_PUSH) begin
                    fin = 1'b1;
                    if (at_limit || (!r_free_ne && fresh_full)) begin
                        op_st = mspc_pkg::ST_OVER_LIMIT;
                    end else begin
                        o_ent_req.we          = 1'b1;
                        o_ent_req.waddr       = push_idx;
                        o_ent_req.wdata.tag   = r_tag;
                        o_ent_req.wdata.below = i_stk_rd.nonempty ? i_stk_rd.top : push_idx;
                        o_stk_req.we             = 1'b1;
                        o_stk_req.waddr          = r_s;
                        o_stk_req.wdata.nonempty = 1'b1;
                        o_stk_req.wdata.top      = push_idx;
                        if (r_free_ne) begin
                            n_free_head = i_ent_rd.below;
                            n_free_ne   = (i_ent_rd.below != r_free_head);
                        end else begin
                            n_fresh = r_fresh + mspc_pkg::FRESH_W'(1);
                        end
                        n_total = r_total + mspc_pkg::TOT_W'(1);
                        if (n_total > r_peak) begin
                            n_peak = n_total;
                        end
                    end
                end else begin
                    if (!i_stk_rd.nonempty) begin
                        fin   = 1'b1;
                        op_st = mspc_pkg::ST_EMPTY_POP;
                    end else begin
                        o_ent_req.raddr = i_stk_rd.top;
                        n_top   = i_stk_rd.top;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                fin = 1'b1;
                if (i_ent_rd.tag != r_tag) begin
                    op_st = mspc_pkg::ST_TAG_MISMATCH;
                end else begin
                    o_stk_req.we             = 1'b1;
                    o_stk_req.waddr          = r_s;
                    o_stk_req.wdata.nonempty = (i_ent_rd.below != r_top);
                    o_stk_req.wdata.top      = i_ent_rd.below;
                    o_ent_req.we          = 1'b1;
                    o_ent_req.waddr       = r_top;
                    o_ent_req.wdata.tag   = i_ent_rd.tag;
                    o_ent_req.wdata.below = r_free_ne ? r_free_head : r_top;
                    n_free_head = r_top;
                    n_free_ne   = 1'b1;
                    if (r_total != '0) begin
                        n_total = r_total - mspc_pkg::TOT_W'(1);
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = r_last ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            res_st = op_st;
            if (op_st != mspc_pkg::ST_OK && op_st != mspc_pkg::ST_IGNORED) begin
                n_err = 1'b1;
            end
            if (r_last && !n_err && n_total != '0) begin
                res_st = mspc_pkg::ST_NOT_EMPTY;
                n_err  = 1'b1;
            end
            res.status     = res_st;
            res.run_failed = n_err;
            res.item_total = mspc_pkg::CNT_W'(n_total);
            res.peak_total = mspc_pkg::CNT_W'(n_peak);
            res.run_done   = r_last;
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = res;
                n_state     = r_last ? S_CLEAR : S_IDLE;
            end else begin
                n_pend  = res;
                n_state = S_HOLD;
            end
            if (r_last) begin
                n_free_head = '0;
                n_free_ne   = 1'b0;
                n_fresh     = '0;
                n_total     = '0;
                n_peak      = '0;
                n_err       = 1'b0;
                n_clr       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_stacks    <= mspc_pkg::STACKS_RESET;
            r_limit     <= mspc_pkg::LIMIT_RESET;
            r_free_head <= '0;
            r_free_ne   <= 1'b0;
            r_fresh     <= '0;
            r_total     <= '0;
            r_peak      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_head <= n_free_head;
            r_free_ne   <= n_free_ne;
            r_fresh     <= n_fresh;
            r_total     <= n_total;
            r_peak      <= n_peak;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (mspc_pkg::t_cfg_idx'(i_cfg_idx))
                    mspc_pkg::CFG_STACKS_IN_USE: r_stacks <= i_cfg_data;
                    mspc_pkg::CFG_ITEM_LIMIT:    r_limit  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (cmd_acc) begin
            r_mode <= i_cmd.mode;
            r_s    <= cmd_s;
            r_tag  <= mspc_pkg::TAG_BITS'(i_cmd.item_tag);
            r_bad  <= cmd_bad;
            r_last <= i_cmd.last_command;
        end
        r_top  <= n_top;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

endmodule

### src/multi_stack_pool_checker.sv
`timescale 1ns / 1ps
// Push/pop checker for numbered LIFO stacks sharing one entry pool. Each accepted
// command yields one result item. A push, a bad stack number, a pop of an empty stack
// or a command of an already failed run goes from acceptance through S_LOOK (read of
// the stack-top and entry memories, then write-back) back to S_IDLE; a pop of a
// non-empty stack also passes S_POP, since the entry read depends on the stack-top read.
// The result item is presented through an output register from the edge that ends the
// last of those states; while it waits, one more command is taken and its result held,
// and input then stalls until the receiver takes the waiting item. After reset and after
// every command marked last, the stack-top memory is swept clean, one row per cycle, over
// all MAX_STACKS (1024) rows, during which no command is accepted; configuration
// writes are taken at any time.
// depends on mspc_pkg, mspc_if, mspc_ram and mspc_core

module multi_stack_pool_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mspc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mspc_pkg::CFG_W-1:0]     i_cfg_data,
    mspc_cmd_if.sink                       i_cmd,
    mspc_res_if.source                     o_res
);

    mspc_pkg::t_stk_req stk_req;
    mspc_pkg::t_stk_row stk_rd;
    mspc_pkg::t_ent_req ent_req;
    mspc_pkg::t_ent_row ent_rd;

    mspc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .o_res      (o_res),
        .o_stk_req  (stk_req),
        .i_stk_rd   (stk_rd),
        .o_ent_req  (ent_req),
        .i_ent_rd   (ent_rd)
    );

    mspc_ram #(
        .DEPTH (mspc_pkg::MAX_STACKS),
        .WIDTH ($bits(mspc_pkg::t_stk_row))
    ) u_stack_top_mem (
        .i_clk   (i_clk),
        .i_we    (stk_req.we),
        .i_waddr (stk_req.waddr),
        .i_wdata (stk_req.wdata),
        .i_raddr (stk_req.raddr),
        .o_rdata (stk_rd)
    );

    mspc_ram #(
        .DEPTH (mspc_pkg::POOL_ENTRIES),
        .WIDTH ($bits(mspc_pkg::t_ent_row))
    ) u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (ent_req.we),
        .i_waddr (ent_req.waddr),
        .i_wdata (ent_req.wdata),
        .i_raddr (ent_req.raddr),
        .o_rdata (ent_rd)
    );

endmodule

### src/mspc_checker.sv
`timescale 1ns / 1ps
// mspc_checker: port-level assertions on the result channel of the checker
// depends on mspc_pkg; bound to multi_stack_pool_checker below

module mspc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [mspc_pkg::STATUS_W-1:0] i_res_status,
    input logic                          i_res_run_failed,
    input logic [mspc_pkg::CNT_W-1:0]    i_res_item_total,
    input logic [mspc_pkg::CNT_W-1:0]    i_res_peak_total,
    input logic                          i_res_run_done
);

    a_ok_not_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status == mspc_pkg::ST_OK |-> !i_res_run_failed)
        else $error("ok result reported with failed run");

    a_error_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status != mspc_pkg::ST_OK |-> i_res_run_failed)
        else $error("error result without failed run");

    a_verdict_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_run_done && i_res_status == mspc_pkg::ST_OK
        |-> i_res_item_total == '0)
        else $error("passing verdict with items left in pool");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_item_total <= i_res_peak_total)
        else $error("item total above peak");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
        && $stable({i_res_status, i_res_run_failed, i_res_item_total,
                    i_res_peak_total, i_res_run_done}))
        else $error("stalled result item changed");

endmodule

bind multi_stack_pool_checker mspc_checker u_mspc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_status     (o_res.status),
    .i_res_run_failed (o_res.run_failed),
    .i_res_item_total (o_res.item_total),
    .i_res_peak_total (o_res.peak_total),
    .i_res_run_done   (o_res.run_done)
);
